// File: hdl/packet_slot_ring_manager_defines.svh
// Assertion macros shared by the slot ring manager RTL.
// No dependencies; every user passes its own clock and reset.
`ifndef PACKET_SLOT_RING_MANAGER_DEFINES_SVH
`define PACKET_SLOT_RING_MANAGER_DEFINES_SVH
`ifndef ASSERT_OFF
`define PSRM_ASSERT_ALWAYS(lbl, clk, rst, cond, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);
`define PSRM_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define PSRM_ASSERT_ALWAYS(lbl, clk, rst, cond, msg)
`define PSRM_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)
`endif
`endif

// File: hdl/psrm_pkg.sv
// Types and constants of the packet slot ring manager.
// No dependencies; used by psrm_ctrl, psrm_dpath and the top level.
package psrm_pkg;

   localparam int MODE_W     = 2;
   localparam int LEN_W      = 13;
   localparam int WORD_W     = 32;
   localparam int THR_W      = 8;
   localparam int TX_SLOT_W  = 2;
   localparam int RX_SLOT_W  = 3;
   localparam int STATUS_W   = 2;
   localparam int LEN_CMP_W  = 17;
   localparam int REQ_DATA_W = 48;
   localparam int RSP_DATA_W = 16;
   localparam int CSR_IDX_W  = 1;

   localparam logic [MODE_W-1:0] MODE_TX_PUSH = 2'd0;
   localparam logic [MODE_W-1:0] MODE_XFER_END = 2'd1;
   localparam logic [MODE_W-1:0] MODE_RX_POP  = 2'd2;

   localparam logic [STATUS_W-1:0] STATUS_OK      = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_TX_FULL = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_RX_EMPTY = 2'd2;
   localparam logic [STATUS_W-1:0] STATUS_FATAL   = 2'd3;

   localparam logic [CSR_IDX_W-1:0] CSR_PEEK_THRESHOLD   = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_MAINTENANCE_MAGIC = 1'b1;

   localparam logic [THR_W-1:0]  PEEK_THRESHOLD_RESET = 8'd16;
   localparam logic [WORD_W-1:0] MAINT_MAGIC_RESET    = 32'h9876fedb;

   typedef struct packed {
      logic [WORD_W-1:0] first_word;
      logic [LEN_W-1:0]  transfer_len;
      logic [MODE_W-1:0] mode;
   } req_type;

   typedef struct packed {
      logic                 maintenance_request;
      logic [RX_SLOT_W-1:0] rx_slot;
      logic [TX_SLOT_W-1:0] tx_slot;
      logic                 tx_send;
      logic [STATUS_W-1:0]  status;
   } rsp_type;

   typedef struct packed {
      logic capture;
      logic commit;
   } cmd_type;

endpackage

// File: hdl/psrm_ctrl.sv
// Controller of the slot ring manager: request capture, commit, response valid.
// Depends on psrm_pkg for the command struct.
module psrm_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output psrm_pkg::cmd_type cmd
);

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_EXEC = 2'b10
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;

   always_comb begin
      state_in    = state_ff;
      cmd.capture = 1'b0;
      cmd.commit  = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               cmd.capture = 1'b1;
               state_in    = ST_EXEC;
            end
         end
         ST_EXEC: begin
            // wait for the response register to drain
            if (out_free) begin
               cmd.commit = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.commit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

// File: hdl/psrm_dpath.sv
// Datapath of the slot ring manager: ring indices, fatal flag, registers, response.
// Depends on psrm_pkg and packet_slot_ring_manager_defines.svh.
`include "packet_slot_ring_manager_defines.svh"
module psrm_dpath #(
   parameter int TX_SLOTS      = 4,
   parameter int RX_SLOTS      = 6,
   parameter int RX_SLOT_BYTES = 6000
) (
   input  logic                               clock,
   input  logic                               reset,
   input  psrm_pkg::cmd_type                  cmd,
   input  psrm_pkg::req_type                  req,
   input  logic                               csr_we,
   input  logic [psrm_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [psrm_pkg::WORD_W-1:0]        csr_wdata,
   output psrm_pkg::rsp_type                  rsp
);

   localparam int TX_W = $clog2(TX_SLOTS);
   localparam int RX_W = $clog2(RX_SLOTS);
   localparam logic [TX_W-1:0] TX_LAST = TX_W'(TX_SLOTS - 1);
   localparam logic [RX_W-1:0] RX_LAST = RX_W'(RX_SLOTS - 1);
   localparam logic [psrm_pkg::LEN_CMP_W-1:0] SLOT_BYTES_EXT =
      psrm_pkg::LEN_CMP_W'(RX_SLOT_BYTES);

   psrm_pkg::req_type req_ff;
   psrm_pkg::rsp_type rsp_ff, rsp_in;

   logic [psrm_pkg::THR_W-1:0]  thr_ff;
   logic [psrm_pkg::WORD_W-1:0] magic_ff;

   logic [TX_W-1:0] tx_wr_ff, tx_wr_in, tx_rd_ff, tx_rd_in;
   logic [RX_W-1:0] rx_wr_ff, rx_wr_in, rx_rd_ff, rx_rd_in;
   logic            fatal_ff, fatal_in;

   logic [TX_W-1:0] tx_wr_nxt, tx_rd_nxt;
   logic [RX_W-1:0] rx_wr_nxt, rx_rd_nxt;
   logic [psrm_pkg::LEN_CMP_W-1:0] len_ext, thr_ext;
   logic            long_xfer;

   assign tx_wr_nxt = (tx_wr_ff >= TX_LAST) ? '0 : tx_wr_ff + 1'b1;
   assign tx_rd_nxt = (tx_rd_ff >= TX_LAST) ? '0 : tx_rd_ff + 1'b1;
   assign rx_wr_nxt = (rx_wr_ff >= RX_LAST) ? '0 : rx_wr_ff + 1'b1;
   assign rx_rd_nxt = (rx_rd_ff >= RX_LAST) ? '0 : rx_rd_ff + 1'b1;

   // clamp to the slot size folded into the compare
   assign len_ext   = psrm_pkg::LEN_CMP_W'(req_ff.transfer_len);
   assign thr_ext   = psrm_pkg::LEN_CMP_W'(thr_ff);
   assign long_xfer = (len_ext >= thr_ext) && (SLOT_BYTES_EXT >= thr_ext);

   always_comb begin
      tx_wr_in = tx_wr_ff;
      tx_rd_in = tx_rd_ff;
      rx_wr_in = rx_wr_ff;
      rx_rd_in = rx_rd_ff;
      fatal_in = fatal_ff;
      rsp_in   = '0;
      if (fatal_ff) begin
         rsp_in.status = psrm_pkg::STATUS_FATAL;
      end else begin
         case (req_ff.mode)
            psrm_pkg::MODE_TX_PUSH: begin
               if (tx_wr_nxt == tx_rd_ff) begin
                  rsp_in.status = psrm_pkg::STATUS_TX_FULL;
               end else begin
                  tx_wr_in       = tx_wr_nxt;
                  rsp_in.tx_slot = psrm_pkg::TX_SLOT_W'(tx_wr_nxt);
               end
            end
            psrm_pkg::MODE_XFER_END: begin
               rsp_in.maintenance_request = (req_ff.first_word == magic_ff);
               if (tx_wr_ff != tx_rd_ff) begin
                  rsp_in.tx_send = 1'b1;
                  if (long_xfer) begin
                     tx_rd_in       = tx_rd_nxt;
                     rsp_in.tx_slot = psrm_pkg::TX_SLOT_W'(tx_rd_nxt);
                  end else begin
                     rsp_in.tx_slot = psrm_pkg::TX_SLOT_W'(tx_rd_ff);
                  end
               end
               rsp_in.rx_slot = psrm_pkg::RX_SLOT_W'(rx_wr_ff);
               if (long_xfer) begin
                  if (rx_wr_nxt == rx_rd_ff) begin
                     fatal_in      = 1'b1;
                     rsp_in.status = psrm_pkg::STATUS_FATAL;
                  end else begin
                     rx_wr_in       = rx_wr_nxt;
                     rsp_in.rx_slot = psrm_pkg::RX_SLOT_W'(rx_wr_nxt);
                  end
               end
            end
            psrm_pkg::MODE_RX_POP: begin
               if (rx_rd_ff != rx_wr_ff) begin
                  rsp_in.rx_slot = psrm_pkg::RX_SLOT_W'(rx_rd_ff);
                  rx_rd_in       = rx_rd_nxt;
               end else begin
                  rsp_in.status = psrm_pkg::STATUS_RX_EMPTY;
               end
            end
            default: rsp_in = '0;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         req_ff <= req;
      end
      if (cmd.commit) begin
         rsp_ff <= rsp_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff   <= psrm_pkg::PEEK_THRESHOLD_RESET;
         magic_ff <= psrm_pkg::MAINT_MAGIC_RESET;
         tx_wr_ff <= '0;
         tx_rd_ff <= '0;
         rx_wr_ff <= '0;
         rx_rd_ff <= '0;
         fatal_ff <= 1'b0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               psrm_pkg::CSR_PEEK_THRESHOLD:    thr_ff   <= csr_wdata[psrm_pkg::THR_W-1:0];
               psrm_pkg::CSR_MAINTENANCE_MAGIC: magic_ff <= csr_wdata;
               default: ;
            endcase
         end
         if (cmd.commit) begin
            tx_wr_ff <= tx_wr_in;
            tx_rd_ff <= tx_rd_in;
            rx_wr_ff <= rx_wr_in;
            rx_rd_ff <= rx_rd_in;
            fatal_ff <= fatal_in;
         end
      end
   end

   assign rsp = rsp_ff;

   `PSRM_ASSERT_NEXT(a_fatal_sticky, clock, reset, fatal_ff, fatal_ff, "fatal flag cleared")
   `PSRM_ASSERT_NEXT(a_fatal_frozen, clock, reset, fatal_ff && cmd.commit,
      $stable(tx_wr_ff) && $stable(tx_rd_ff) && $stable(rx_wr_ff) && $stable(rx_rd_ff),
      "ring index moved while fatal")
   `PSRM_ASSERT_ALWAYS(a_idx_range, clock, reset,
      (tx_wr_ff <= TX_LAST) && (tx_rd_ff <= TX_LAST) && (rx_wr_ff <= RX_LAST) &&
      (rx_rd_ff <= RX_LAST), "ring index beyond ring size")

endmodule

// File: hdl/packet_slot_ring_manager.sv
// Top level of the packet slot ring manager.
// Depends on psrm_pkg, psrm_ctrl and psrm_dpath.
//
// Use:
//   req_ channel: one request per event (transmit push, SPI transfer end,
//   receive pop). req_tdata carries mode, transfer_len and first_word.
//   rsp_ channel: exactly one response per request, in request order,
//   carrying status, tx_send, tx_slot, rx_slot and maintenance_request.
//   csr_ channel: register writes (0 peek threshold, 1 maintenance magic),
//   taken in any cycle; write only while no request is outstanding.
// Order: a request accepted at one edge is evaluated in the next cycle
//   and its response is registered when the controller commits it.
// Flow: a new request waits until the last one commits (capture/commit
//   sequence of the controller); req_tready is high in its idle state.
// Stall: a held response stays in the response register; the next request
//   is still captured, and its commit waits until the response is taken.
// Reset: indices and the fatal flag clear, registers return to their
//   defaults (threshold 16, magic 0x9876fedb), no response pending.
module packet_slot_ring_manager #(
   parameter int TX_SLOTS      = 4,
   parameter int RX_SLOTS      = 6,
   parameter int RX_SLOT_BYTES = 6000
) (
   input  logic                                 clock,
   input  logic                                 reset,
   // request channel
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   // [1:0] mode, [14:2] transfer_len, [46:15] first_word, [47] zero
   input  logic [psrm_pkg::REQ_DATA_W-1:0]      req_tdata,
   // response channel
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   // [1:0] status, [2] tx_send, [4:3] tx_slot, [7:5] rx_slot,
   // [8] maintenance_request, [15:9] zero
   output logic [psrm_pkg::RSP_DATA_W-1:0]      rsp_tdata,
   // register write channel
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [psrm_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [psrm_pkg::WORD_W-1:0]          csr_wdata
);

   psrm_pkg::cmd_type cmd;
   psrm_pkg::req_type req;
   psrm_pkg::rsp_type rsp;

   // registers are plain flops: always accept a write
   assign csr_ready = 1'b1;

   // unpack the request, drop the pad bit
   assign req = req_tdata[$bits(psrm_pkg::req_type)-1:0];

   // pack the response, zero-fill to whole bytes
   assign rsp_tdata = psrm_pkg::RSP_DATA_W'(rsp);

   psrm_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd)
   );

   psrm_dpath #(
      .TX_SLOTS      (TX_SLOTS),
      .RX_SLOTS      (RX_SLOTS),
      .RX_SLOT_BYTES (RX_SLOT_BYTES)
   ) u_dpath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .req       (req),
      .csr_we    (csr_valid && csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .rsp       (rsp)
   );

endmodule

// File: sim/packet_slot_ring_manager_test.sv
`timescale 1ns / 1ps
// Self-checking testbench of packet_slot_ring_manager: directed and random events on the
// request stream, checked against an in-house model of the two slot rings.
// Depends on psrm_pkg and the packet_slot_ring_manager RTL only.
module packet_slot_ring_manager_test;

   localparam int TX_SLOTS      = 4;
   localparam int RX_SLOTS      = 6;
   localparam int RX_SLOT_BYTES = 6000;
   localparam int LEN_MAX       = (1 << psrm_pkg::LEN_W) - 1;

   // The fourth mode code has no meaning; the block must ignore it.
   localparam logic [psrm_pkg::MODE_W-1:0] MODE_UNUSED = 2'd3;

   // Cycles without any handshake before the run is declared hung. The longest
   // legitimate quiet stretch is the receiver hold-off below.
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int HOLD_CYCLES    = 300;
   localparam int DRAIN_CYCLES   = 4;

   // Slot ring model and response store. Expected responses are queued when a
   // request is accepted and retired in order as responses arrive.
   class slot_ring_scoreboard_type;
      logic [psrm_pkg::THR_W-1:0]  peek_threshold;
      logic [psrm_pkg::WORD_W-1:0] maint_magic;
      int                          tx_wr, tx_rd, rx_wr, rx_rd;
      bit                          fatal_flag;
      psrm_pkg::rsp_type           pending[$];
      int                          errors;
      int                          checked;

      function new();
         peek_threshold = psrm_pkg::PEEK_THRESHOLD_RESET;
         maint_magic    = psrm_pkg::MAINT_MAGIC_RESET;
         tx_wr      = 0;
         tx_rd      = 0;
         rx_wr      = 0;
         rx_rd      = 0;
         fatal_flag = 1'b0;
         errors     = 0;
         checked    = 0;
      endfunction

      function int ring_next(int idx, int slots);
         return (idx + 1 >= slots) ? 0 : idx + 1;
      endfunction

      function void write_reg(logic [psrm_pkg::CSR_IDX_W-1:0] idx,
                              logic [psrm_pkg::WORD_W-1:0] data);
         if (idx == psrm_pkg::CSR_PEEK_THRESHOLD)
            peek_threshold = data[psrm_pkg::THR_W-1:0];
         else if (idx == psrm_pkg::CSR_MAINTENANCE_MAGIC)
            maint_magic = data;
      endfunction

      // Advance the rings for one accepted request and queue its response.
      function void note_request(psrm_pkg::req_type r);
         psrm_pkg::rsp_type want;
         int                len;
         int                n;
         bit                long_xfer;
         want = '0;
         len  = int'(r.transfer_len);
         if (len > RX_SLOT_BYTES)
            len = RX_SLOT_BYTES;
         long_xfer = (len >= int'(peek_threshold));
         if (fatal_flag) begin
            want.status = psrm_pkg::STATUS_FATAL;
         end else begin
            case (r.mode)
               psrm_pkg::MODE_TX_PUSH: begin
                  n = ring_next(tx_wr, TX_SLOTS);
                  if (n == tx_rd) begin
                     want.status = psrm_pkg::STATUS_TX_FULL;
                  end else begin
                     tx_wr        = n;
                     want.tx_slot = psrm_pkg::TX_SLOT_W'(n);
                  end
               end
               psrm_pkg::MODE_XFER_END: begin
                  want.maintenance_request = (r.first_word == maint_magic);
                  // Pending transmit data: advance first on a full transfer, then arm.
                  if (tx_wr != tx_rd) begin
                     if (long_xfer)
                        tx_rd = ring_next(tx_rd, TX_SLOTS);
                     want.tx_send = 1'b1;
                     want.tx_slot = psrm_pkg::TX_SLOT_W'(tx_rd);
                  end
                  if (long_xfer) begin
                     n = ring_next(rx_wr, RX_SLOTS);
                     if (n == rx_rd) begin
                        fatal_flag  = 1'b1;
                        want.status = psrm_pkg::STATUS_FATAL;
                     end else begin
                        rx_wr = n;
                     end
                  end
                  want.rx_slot = psrm_pkg::RX_SLOT_W'(rx_wr);
               end
               psrm_pkg::MODE_RX_POP: begin
                  if (rx_rd != rx_wr) begin
                     want.rx_slot = psrm_pkg::RX_SLOT_W'(rx_rd);
                     rx_rd        = ring_next(rx_rd, RX_SLOTS);
                  end else begin
                     want.status = psrm_pkg::STATUS_RX_EMPTY;
                  end
               end
               default: ;
            endcase
         end
         pending.push_back(want);
      endfunction

      task report_mismatch(string field, int got, int want);
         errors++;
         if (errors <= 100)
            $display("[%0t] response %0d: %s got 0x%0h, expected 0x%0h",
                     $time, checked, field, got, want);
      endtask

      task check_response(psrm_pkg::rsp_type got);
         psrm_pkg::rsp_type want;
         checked++;
         if (pending.size() == 0) begin
            report_mismatch("unexpected response", int'(got), 0);
         end else begin
            want = pending.pop_front();
            if (got.status !== want.status)
               report_mismatch("status", int'(got.status), int'(want.status));
            if (got.tx_send !== want.tx_send)
               report_mismatch("tx_send", int'(got.tx_send), int'(want.tx_send));
            if (got.tx_slot !== want.tx_slot)
               report_mismatch("tx_slot", int'(got.tx_slot), int'(want.tx_slot));
            if (got.rx_slot !== want.rx_slot)
               report_mismatch("rx_slot", int'(got.rx_slot), int'(want.rx_slot));
            if (got.maintenance_request !== want.maintenance_request)
               report_mismatch("maintenance_request", int'(got.maintenance_request),
                               int'(want.maintenance_request));
         end
      endtask
   endclass

   logic                              clock = 1'b0;
   logic                              reset = 1'b1;
   logic                              req_tvalid = 1'b0;
   logic                              req_tready;
   logic [psrm_pkg::REQ_DATA_W-1:0]   req_tdata = '0;
   logic                              rsp_tvalid;
   logic                              rsp_tready = 1'b0;
   logic [psrm_pkg::RSP_DATA_W-1:0]   rsp_tdata;
   logic                              csr_valid = 1'b0;
   logic                              csr_ready;
   logic [psrm_pkg::CSR_IDX_W-1:0]    csr_index = '0;
   logic [psrm_pkg::WORD_W-1:0]       csr_wdata = '0;

   slot_ring_scoreboard_type          sb;
   bit                                idle_on  = 1'b0;   // random gaps on both sides
   bit                                hold_rsp = 1'b0;   // one long receiver hold-off
   int                                quiet_cycles = 0;

   packet_slot_ring_manager #(
      .TX_SLOTS      (TX_SLOTS),
      .RX_SLOTS      (RX_SLOTS),
      .RX_SLOT_BYTES (RX_SLOT_BYTES)
   ) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Gap length: mostly short, now and then long. Zero only where allowed.
   function automatic int pick_gap(bit allow_zero);
      int roll;
      roll = $urandom_range(0, 99);
      if (!idle_on)
         return allow_zero ? 0 : 1;
      if (allow_zero && roll < 55)
         return 0;
      if (roll < 90)
         return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   function automatic psrm_pkg::req_type make_request(logic [psrm_pkg::MODE_W-1:0] mode,
                                                      int len,
                                                      logic [psrm_pkg::WORD_W-1:0] word);
      psrm_pkg::req_type r;
      r.mode         = mode;
      r.transfer_len = len[psrm_pkg::LEN_W-1:0];
      r.first_word   = word;
      return r;
   endfunction

   // Random event drawn against the current ring state. A full transfer that
   // would overrun the receive ring becomes a pop, so the sticky fatal state
   // is kept for the final phase and the rings stay alive meanwhile.
   function automatic psrm_pkg::req_type random_request();
      psrm_pkg::req_type r;
      int                roll;
      int                thr;
      int                len;
      roll = $urandom_range(0, 99);
      thr  = int'(sb.peek_threshold);
      if (roll < 30)
         r.mode = psrm_pkg::MODE_TX_PUSH;
      else if (roll < 65)
         r.mode = psrm_pkg::MODE_XFER_END;
      else if (roll < 95)
         r.mode = psrm_pkg::MODE_RX_POP;
      else
         r.mode = MODE_UNUSED;
      roll = $urandom_range(0, 99);
      if (roll < 25 && thr > 0)
         len = $urandom_range(0, thr - 1);
      else if (roll < 35)
         len = (thr > 0 && roll < 30) ? thr - 1 : thr;
      else if (roll < 45)
         len = $urandom_range(RX_SLOT_BYTES + 1, LEN_MAX);
      else if (roll < 55)
         len = $urandom_range(0, LEN_MAX);
      else
         len = $urandom_range(thr, RX_SLOT_BYTES);
      r.transfer_len = len[psrm_pkg::LEN_W-1:0];
      r.first_word   = ($urandom_range(0, 99) < 15) ? sb.maint_magic : $urandom;
      if (len > RX_SLOT_BYTES)
         len = RX_SLOT_BYTES;
      if (r.mode == psrm_pkg::MODE_XFER_END && len >= thr
          && sb.ring_next(sb.rx_wr, RX_SLOTS) == sb.rx_rd)
         r.mode = psrm_pkg::MODE_RX_POP;
      return r;
   endfunction

   // Offer one request, hold it until taken, then leave a gap if one is drawn.
   // Valid stays high across back-to-back requests.
   task automatic issue_request(psrm_pkg::req_type r);
      int gap;
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tdata  <= {1'b0, r};
      do @(posedge clock); while (!req_tready);
      sb.note_request(r);
      gap = pick_gap(1'b1);
      if (gap > 0) begin
         @(negedge clock);
         req_tvalid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
   endtask

   // Drop valid and wait until every expected response is in, plus a margin.
   task automatic wait_idle();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(logic [psrm_pkg::CSR_IDX_W-1:0] idx,
                            logic [psrm_pkg::WORD_W-1:0] data);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
      sb.write_reg(idx, data);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic random_phase(int count, logic [psrm_pkg::THR_W-1:0] thr,
                               logic [psrm_pkg::WORD_W-1:0] magic, bit with_gaps);
      wait_idle();
      write_csr(psrm_pkg::CSR_PEEK_THRESHOLD,
                {{(psrm_pkg::WORD_W-psrm_pkg::THR_W){1'b0}}, thr});
      write_csr(psrm_pkg::CSR_MAINTENANCE_MAGIC, magic);
      idle_on = with_gaps;
      repeat (count) issue_request(random_request());
   endtask

   // Response side: take responses with random stalls, or hold off for a long
   // stretch once when asked so that the block backs up onto its request port.
   initial begin : response_sink
      bit hold_done;
      wait (!reset);
      forever begin
         @(negedge clock);
         if (hold_rsp && !hold_done) begin
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES - 1) @(negedge clock);
            hold_done = 1'b1;
         end else if (idle_on && $urandom_range(0, 3) == 0) begin
            rsp_tready <= 1'b0;
            repeat (pick_gap(1'b0) - 1) @(negedge clock);
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // Check every response taken at a rising edge.
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         sb.check_response(rsp_tdata[$bits(psrm_pkg::rsp_type)-1:0]);
   end

   // Watchdog: end the run if no channel moves for too long.
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)
          || (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else begin
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
         end
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin : stimulus
      sb = new();
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed events on the reset configuration, no gaps.
      idle_on = 1'b0;
      // receive empty
      issue_request(make_request(psrm_pkg::MODE_RX_POP, 0, '0));
      // peek, nothing to send
      issue_request(make_request(psrm_pkg::MODE_XFER_END, 0, psrm_pkg::MAINT_MAGIC_RESET));
      issue_request(make_request(psrm_pkg::MODE_TX_PUSH, LEN_MAX, '1));
      issue_request(make_request(psrm_pkg::MODE_TX_PUSH, 0, '0));
      issue_request(make_request(psrm_pkg::MODE_TX_PUSH, 100, 32'h5a5a_a5a5));
      // transmit full
      issue_request(make_request(psrm_pkg::MODE_TX_PUSH, 0, '0));
      // peek with data pending
      issue_request(make_request(psrm_pkg::MODE_XFER_END, 15, '0));
      // advance then arm
      issue_request(make_request(psrm_pkg::MODE_XFER_END, 16, '1));
      issue_request(make_request(psrm_pkg::MODE_XFER_END, LEN_MAX,
                                 psrm_pkg::MAINT_MAGIC_RESET ^ 32'h1));
      issue_request(make_request(psrm_pkg::MODE_RX_POP, LEN_MAX, '1));
      // ignored mode
      issue_request(make_request(MODE_UNUSED, LEN_MAX, '1));
      issue_request(make_request(MODE_UNUSED, 0, '0));
      issue_request(make_request(psrm_pkg::MODE_XFER_END, RX_SLOT_BYTES,
                                 psrm_pkg::MAINT_MAGIC_RESET));
      issue_request(make_request(psrm_pkg::MODE_XFER_END, RX_SLOT_BYTES + 1, 32'h0000_0001));
      issue_request(make_request(psrm_pkg::MODE_RX_POP, 0, '0));
      issue_request(make_request(psrm_pkg::MODE_RX_POP, 0, '0));
      issue_request(make_request(psrm_pkg::MODE_RX_POP, 0, '0));
      issue_request(make_request(psrm_pkg::MODE_RX_POP, 0, '0));
      // tx ring drained
      issue_request(make_request(psrm_pkg::MODE_XFER_END, 16, 32'h8000_0000));
      issue_request(make_request(psrm_pkg::MODE_TX_PUSH, 0, '0));

      // Random phases across threshold and magic settings, extremes included.
      random_phase(120, 8'd0, '0, 1'b1);
      random_phase(120, 8'd255, '1, 1'b1);
      random_phase(100, psrm_pkg::THR_W'($urandom_range(1, 254)), $urandom, 1'b0);

      // Back-pressure: hold the response side while requests keep coming.
      wait_idle();
      write_csr(psrm_pkg::CSR_PEEK_THRESHOLD,
                psrm_pkg::WORD_W'(psrm_pkg::PEEK_THRESHOLD_RESET));
      idle_on  = 1'b0;
      hold_rsp = 1'b1;
      repeat (100) issue_request(random_request());

      random_phase(140, psrm_pkg::THR_W'($urandom_range(1, 254)), $urandom, 1'b1);
      random_phase(120, psrm_pkg::PEEK_THRESHOLD_RESET, psrm_pkg::MAINT_MAGIC_RESET, 1'b1);

      // Receive overrun: every transfer is full with a zero threshold, so the
      // ring overflows within a few events; afterwards everything is fatal.
      wait_idle();
      write_csr(psrm_pkg::CSR_PEEK_THRESHOLD, '0);
      while (!sb.fatal_flag)
         issue_request(make_request(psrm_pkg::MODE_XFER_END,
                                    $urandom_range(0, LEN_MAX), $urandom));
      issue_request(make_request(psrm_pkg::MODE_TX_PUSH, 0, '0));
      issue_request(make_request(psrm_pkg::MODE_XFER_END, 100, sb.maint_magic));
      issue_request(make_request(psrm_pkg::MODE_RX_POP, 0, '0));
      issue_request(make_request(MODE_UNUSED, 0, '0));
      issue_request(make_request(psrm_pkg::MODE_XFER_END, 0, '0));

      wait_idle();
      if (sb.errors == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule

// File: sim.f
+incdir+hdl
hdl/psrm_pkg.sv
hdl/psrm_ctrl.sv
hdl/psrm_dpath.sv
hdl/packet_slot_ring_manager.sv
sim/packet_slot_ring_manager_test.sv
